>>> src/info_frame_deframer_defines.svh
// Assertion macros for the frame deframer.
`ifndef INFO_FRAME_DEFRAMER_DEFINES_SVH
`define INFO_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property, checked at every edge outside reset
`define IFD_ASSERT(label, ck, rstn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
        else $error(msg);

// Same-cycle implication
`define IFD_ASSERT_IMPL(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define IFD_ASSERT(label, ck, rstn, prop, msg)
`define IFD_ASSERT_IMPL(label, ck, rstn, ante, cons, msg)

`endif

`endif

>>> src/ifd_pkg.sv
package ifd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned LenW  = 11;
    localparam int unsigned CfgIdxW = 3;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_CHKERR  = 3'd2,
        KIND_DUP     = 3'd3,
        KIND_ABORT   = 3'd4
    } kind_t;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_FLAG       = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ESCAPE     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_FLAG_ESC   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ESCAPE_ESC = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_ADDRESS    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_CTRL_SEQ0  = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_CTRL_SEQ1  = 3'd6;

    // Register reset values
    localparam logic [ByteW-1:0] FLAG_RST       = 8'd126;
    localparam logic [ByteW-1:0] ESCAPE_RST     = 8'd125;
    localparam logic [ByteW-1:0] FLAG_ESC_RST   = 8'd94;
    localparam logic [ByteW-1:0] ESCAPE_ESC_RST = 8'd93;
    localparam logic [ByteW-1:0] ADDRESS_RST    = 8'd3;
    localparam logic [ByteW-1:0] CTRL_SEQ0_RST  = 8'd0;
    localparam logic [ByteW-1:0] CTRL_SEQ1_RST  = 8'd64;

endpackage

>>> src/ifd_ifs.sv
// Line byte channel
interface ifd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframer result channel
interface ifd_out_if import ifd_pkg::*; ();
    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [ByteW-1:0]  payload_byte;
    logic [LenW-1:0]   frame_length;
    logic              seq_bit;
    logic              frame_end;

    modport source (output valid, output kind, output payload_byte, output frame_length,
                    output seq_bit, output frame_end, input ready);
    modport sink   (input valid, input kind, input payload_byte, input frame_length,
                    input seq_bit, input frame_end, output ready);
endinterface

>>> src/info_frame_deframer.sv
// Channel   | Dir | Payload                                            | Handshake
// ----------+-----+----------------------------------------------------+------------
// rx        | in  | rx_byte                                            | valid/ready
// result    | out | kind, payload_byte, frame_length, seq_bit,         | valid/ready
//           |     | frame_end                                          |
// cfg       | in  | cfg_index, cfg_data                                | cfg_we only
//
// One line byte per cycle unless the stall below holds it: input register, then compare/XOR
// logic into the result register, which is loaded when the staged byte advances.
// rx.ready drops only when a byte in the input register makes a result and the result
// register is full and not being taken. Reset (rst_n low, async) returns to flag hunt,
// sequence bit zero, default delimiter/escape/address/control values.
`include "info_frame_deframer_defines.svh"

module info_frame_deframer
    import ifd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    ifd_in_if.sink             rx,
    ifd_out_if.source          result,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [ByteW-1:0]   cfg_data
);

    localparam logic [LenW-1:0] LenCap =
        (MAX_PAYLOAD > 2047) ? 11'd2047 : LenW'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_FLAG = 3'd1,
        ST_ADDR = 3'd2,
        ST_CTRL = 3'd3,
        ST_DATA = 3'd4,
        ST_ESC  = 3'd5
    } parse_state_t;

    // Configuration registers
    logic [ByteW-1:0] flag_reg, escape_reg, flag_esc_reg, escape_esc_reg;
    logic [ByteW-1:0] address_reg, ctrl0_reg, ctrl1_reg;

    // Input stage
    logic             stage_valid_reg, stage_valid_next;
    logic [ByteW-1:0] stage_byte_reg;

    // Parser state
    parse_state_t     state_reg, state_next;
    logic             exp_seq_reg, exp_seq_next;
    logic [ByteW-1:0] held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic [ByteW-1:0] check_reg, check_next;
    logic [LenW-1:0]  count_reg, count_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    kind_t            kind_reg, kind_next;
    logic [ByteW-1:0] pay_reg, pay_next;
    logic [LenW-1:0]  len_reg, len_next;
    logic             seq_reg, seq_next;
    logic             end_reg, end_next;

    // Step results for the staged byte
    logic             emit_c;
    kind_t            kind_c;
    logic [ByteW-1:0] pay_c;
    logic [LenW-1:0]  len_c;
    logic             seq_c;
    logic             take_c;
    logic [ByteW-1:0] take_byte_c;
    parse_state_t     state_c;
    logic             exp_seq_c;
    logic [ByteW-1:0] held_c;
    logic             held_valid_c;
    logic [ByteW-1:0] check_c;
    logic [LenW-1:0]  count_c;

    logic             advance;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] exp_ctrl, oth_ctrl;
    logic             good;

    assign b        = stage_byte_reg;
    assign exp_ctrl = exp_seq_reg ? ctrl1_reg : ctrl0_reg;
    assign oth_ctrl = exp_seq_reg ? ctrl0_reg : ctrl1_reg;
    assign good     = held_valid_reg && (check_reg == held_reg);

    // Parse step on the staged byte
    always_comb
    begin
        state_c      = state_reg;
        exp_seq_c    = exp_seq_reg;
        held_c       = held_reg;
        held_valid_c = held_valid_reg;
        check_c      = check_reg;
        count_c      = count_reg;
        emit_c       = 1'b0;
        kind_c       = KIND_PAYLOAD;
        pay_c        = '0;
        len_c        = '0;
        seq_c        = exp_seq_reg;
        take_c       = 1'b0;
        take_byte_c  = b;

        unique case (state_reg)
            ST_FLAG:
            begin
                if (b != flag_reg)
                begin
                    state_c = (b == address_reg) ? ST_ADDR : ST_HUNT;
                end
            end
            ST_ADDR:
            begin
                if (b == flag_reg)
                begin
                    state_c = ST_FLAG;
                end
                else if (b == exp_ctrl)
                begin
                    state_c = ST_CTRL;
                end
                else
                begin
                    state_c = ST_HUNT;
                    if (b == oth_ctrl)
                    begin
                        emit_c = 1'b1;
                        kind_c = KIND_DUP;
                        seq_c  = ~exp_seq_reg;
                    end
                end
            end
            ST_CTRL:
            begin
                if (b == flag_reg)
                begin
                    state_c = ST_FLAG;
                end
                else if (b == (address_reg ^ exp_ctrl))
                begin
                    state_c      = ST_DATA;
                    check_c      = b;
                    held_c       = '0;
                    held_valid_c = 1'b0;
                    count_c      = '0;
                end
                else
                begin
                    state_c = ST_HUNT;
                end
            end
            ST_DATA:
            begin
                if (b == flag_reg)
                begin
                    state_c = ST_HUNT;
                    emit_c  = 1'b1;
                    kind_c  = good ? KIND_GOOD : KIND_CHKERR;
                    len_c   = count_reg;
                    if (good)
                    begin
                        exp_seq_c = ~exp_seq_reg;
                    end
                end
                else if (b == escape_reg)
                begin
                    state_c = ST_ESC;
                end
                else
                begin
                    take_c = 1'b1;
                end
            end
            ST_ESC:
            begin
                if (b == flag_reg)
                begin
                    state_c = ST_HUNT;
                    emit_c  = 1'b1;
                    kind_c  = KIND_ABORT;
                    len_c   = count_reg;
                end
                else
                begin
                    state_c = ST_DATA;
                    if (b == flag_esc_reg)
                    begin
                        take_c      = 1'b1;
                        take_byte_c = flag_reg;
                    end
                    else if (b == escape_esc_reg)
                    begin
                        take_c      = 1'b1;
                        take_byte_c = escape_reg;
                    end
                end
            end
            default:
            begin
                state_c = (b == flag_reg) ? ST_FLAG : ST_HUNT;
            end
        endcase

        // One-byte delay: the older destuffed byte goes out as payload
        if (take_c)
        begin
            if (held_valid_reg)
            begin
                emit_c  = 1'b1;
                kind_c  = KIND_PAYLOAD;
                pay_c   = held_reg;
                check_c = check_reg ^ held_reg;
                if (count_reg < LenCap)
                begin
                    count_c = count_reg + 1'b1;
                end
            end
            held_c       = take_byte_c;
            held_valid_c = 1'b1;
        end
    end

    // Handshake: stall only when a result has nowhere to go
    assign advance  = stage_valid_reg && (!emit_c || !out_valid_reg || result.ready);
    assign rx.ready = !stage_valid_reg || advance;

    always_comb
    begin
        stage_valid_next = rx.ready ? rx.valid : stage_valid_reg;
        state_next       = advance ? state_c : state_reg;
        exp_seq_next     = advance ? exp_seq_c : exp_seq_reg;
        held_next        = advance ? held_c : held_reg;
        held_valid_next  = advance ? held_valid_c : held_valid_reg;
        check_next       = advance ? check_c : check_reg;
        count_next       = advance ? count_c : count_reg;

        if (advance && emit_c)
        begin
            out_valid_next = 1'b1;
            kind_next      = kind_c;
            pay_next       = pay_c;
            len_next       = len_c;
            seq_next       = seq_c;
            end_next       = (kind_c != KIND_PAYLOAD);
        end
        else
        begin
            out_valid_next = out_valid_reg && !result.ready;
            kind_next      = kind_reg;
            pay_next       = pay_reg;
            len_next       = len_reg;
            seq_next       = seq_reg;
            end_next       = end_reg;
        end
    end

    // State, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg        <= FLAG_RST;
            escape_reg      <= ESCAPE_RST;
            flag_esc_reg    <= FLAG_ESC_RST;
            escape_esc_reg  <= ESCAPE_ESC_RST;
            address_reg     <= ADDRESS_RST;
            ctrl0_reg       <= CTRL_SEQ0_RST;
            ctrl1_reg       <= CTRL_SEQ1_RST;
            stage_valid_reg <= 1'b0;
            stage_byte_reg  <= '0;
            state_reg       <= ST_HUNT;
            exp_seq_reg     <= 1'b0;
            held_reg        <= '0;
            held_valid_reg  <= 1'b0;
            check_reg       <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            kind_reg        <= KIND_PAYLOAD;
            pay_reg         <= '0;
            len_reg         <= '0;
            seq_reg         <= 1'b0;
            end_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FLAG:       flag_reg       <= cfg_data;
                    CFG_ESCAPE:     escape_reg     <= cfg_data;
                    CFG_FLAG_ESC:   flag_esc_reg   <= cfg_data;
                    CFG_ESCAPE_ESC: escape_esc_reg <= cfg_data;
                    CFG_ADDRESS:    address_reg    <= cfg_data;
                    CFG_CTRL_SEQ0:  ctrl0_reg      <= cfg_data;
                    CFG_CTRL_SEQ1:  ctrl1_reg      <= cfg_data;
                    default:        ;
                endcase
            end
            if (rx.ready && rx.valid)
            begin
                stage_byte_reg <= rx.rx_byte;
            end
            stage_valid_reg <= stage_valid_next;
            state_reg       <= state_next;
            exp_seq_reg     <= exp_seq_next;
            held_reg        <= held_next;
            held_valid_reg  <= held_valid_next;
            check_reg       <= check_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
            kind_reg        <= kind_next;
            pay_reg         <= pay_next;
            len_reg         <= len_next;
            seq_reg         <= seq_next;
            end_reg         <= end_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = kind_reg;
    assign result.payload_byte = pay_reg;
    assign result.frame_length = len_reg;
    assign result.seq_bit      = seq_reg;
    assign result.frame_end    = end_reg;

    // Checks
    `IFD_ASSERT_IMPL(a_end_matches_kind, clk, rst_n, out_valid_reg,
                     end_reg == (kind_reg != KIND_PAYLOAD), "frame_end disagrees with kind")
    `IFD_ASSERT(a_count_capped, clk, rst_n, count_reg <= LenCap, "byte count above cap")
    `IFD_ASSERT_IMPL(a_seq_toggle_on_good, clk, rst_n, exp_seq_reg != $past(exp_seq_reg),
                     $past(advance && emit_c && (kind_c == KIND_GOOD)),
                     "sequence bit toggled without good frame")
    `IFD_ASSERT_IMPL(a_stall_needs_result, clk, rst_n, !rx.ready,
                     stage_valid_reg && emit_c && out_valid_reg,
                     "input stalled with no pending result")

endmodule

>>> test/tb_info_frame_deframer.sv
`timescale 1ns / 100ps

module tb_info_frame_deframer;
    import ifd_pkg::*;

    localparam int unsigned MAX_PAYLOAD = 1024;
    localparam logic [LenW-1:0] LEN_CAP = (MAX_PAYLOAD > 2047) ? 11'd2047 : MAX_PAYLOAD[LenW-1:0];
    localparam int unsigned IDLE_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES = 8;

    // Receiver parse states
    typedef enum logic [2:0] {
        PS_HUNT,
        PS_FLAG,
        PS_ADDR,
        PS_CTRL,
        PS_DATA,
        PS_ESC
    } parse_state_t;

    // One result item
    typedef struct packed {
        kind_t            kind;
        logic [ByteW-1:0] payload_byte;
        logic [LenW-1:0]  frame_length;
        logic             seq_bit;
        logic             frame_end;
    } frame_res_t;

    // One line byte, with a hand-written frame-end result where one is given
    typedef struct packed {
        logic [ByteW-1:0] rx;
        logic             typed;
        kind_t            kind;
        logic [LenW-1:0]  len;
        logic             seq;
    } line_item_t;

    // Directed bytes, default registers, straight after reset
    localparam int unsigned DIR_ROWS = 29;
    localparam line_item_t DIR_TABLE [DIR_ROWS] = '{
        '{8'h7E, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},  // open
        '{8'h03, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h7E, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},  // flag where control due: reopen
        '{8'h03, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h03, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},  // header check
        '{8'hFF, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h7D, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h5E, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},  // stuffed flag
        '{8'h7D, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h11, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},  // unknown escape, dropped
        '{8'h7D, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h5D, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},  // stuffed escape
        '{8'hFF, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},  // trailing check
        '{8'h7E, 1'b1, KIND_GOOD,    11'd3, 1'b0},
        '{8'h7E, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h03, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h00, 1'b1, KIND_DUP,     11'd0, 1'b0},  // old sequence bit
        '{8'h7E, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h03, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h40, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h43, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h7D, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h7E, 1'b1, KIND_ABORT,   11'd0, 1'b1},  // flag after escape
        '{8'h7E, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h03, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h40, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h43, 1'b0, KIND_PAYLOAD, 11'd0, 1'b0},
        '{8'h7E, 1'b1, KIND_CHKERR,  11'd0, 1'b1}   // empty frame
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [ByteW-1:0] cfg_data;

    ifd_in_if  rx_ch ();
    ifd_out_if res_ch ();

    info_frame_deframer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register shadow and receiver state of the predictor
    logic [ByteW-1:0] reg_val [8];
    parse_state_t     pstate = PS_HUNT;
    logic             exp_seq = 1'b0;
    logic [ByteW-1:0] held_byte = '0;
    logic             held_valid = 1'b0;
    logic [ByteW-1:0] running_chk = '0;
    logic [LenW-1:0]  byte_cnt = '0;

    frame_res_t       expected_q [$];
    line_item_t       sent_q [$];
    logic [ByteW-1:0] line_q [$];
    logic             gen_seq = 1'b0;
    bit               source_gaps_on = 1'b1;
    bit               sink_stalls_on = 1'b1;
    int unsigned      error_count = 0;
    int unsigned      idle_cycles = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic frame_res_t mk_result(input kind_t k, input logic [ByteW-1:0] p,
                                             input logic [LenW-1:0] len, input logic s,
                                             input logic e);
        frame_res_t r;
        r.kind = k;
        r.payload_byte = p;
        r.frame_length = len;
        r.seq_bit = s;
        r.frame_end = e;
        return r;
    endfunction

    // One-byte delay: the new destuffed byte is held, the older one goes out
    function automatic void shift_in_data(input logic [ByteW-1:0] d, inout bit has,
                                          inout frame_res_t r);
        if (held_valid)
        begin
            has = 1'b1;
            r = mk_result(KIND_PAYLOAD, held_byte, '0, exp_seq, 1'b0);
            running_chk = running_chk ^ held_byte;
            if (byte_cnt < LEN_CAP) byte_cnt = byte_cnt + 1'b1;
        end
        held_byte = d;
        held_valid = 1'b1;
    endfunction

    // Deframer prediction for one accepted line byte
    function automatic void deframe_step(input logic [ByteW-1:0] b, output bit has,
                                         output frame_res_t r);
        logic [ByteW-1:0] flag;
        logic [ByteW-1:0] esc;
        logic [ByteW-1:0] addr;
        logic [ByteW-1:0] exp_ctrl;
        logic [ByteW-1:0] oth_ctrl;
        bit good;
        flag = reg_val[CFG_FLAG];
        esc = reg_val[CFG_ESCAPE];
        addr = reg_val[CFG_ADDRESS];
        exp_ctrl = exp_seq ? reg_val[CFG_CTRL_SEQ1] : reg_val[CFG_CTRL_SEQ0];
        oth_ctrl = exp_seq ? reg_val[CFG_CTRL_SEQ0] : reg_val[CFG_CTRL_SEQ1];
        has = 1'b0;
        r = '0;
        case (pstate)
            PS_FLAG:
            begin
                if (b != flag) pstate = (b == addr) ? PS_ADDR : PS_HUNT;
            end
            PS_ADDR:
            begin
                if (b == flag) pstate = PS_FLAG;
                else if (b == exp_ctrl) pstate = PS_CTRL;
                else
                begin
                    pstate = PS_HUNT;
                    if (b == oth_ctrl)
                    begin
                        has = 1'b1;
                        r = mk_result(KIND_DUP, '0, '0, ~exp_seq, 1'b1);
                    end
                end
            end
            PS_CTRL:
            begin
                if (b == flag) pstate = PS_FLAG;
                else if (b == (addr ^ exp_ctrl))
                begin
                    pstate = PS_DATA;
                    running_chk = b;
                    held_byte = '0;
                    held_valid = 1'b0;
                    byte_cnt = '0;
                end
                else pstate = PS_HUNT;
            end
            PS_DATA:
            begin
                if (b == flag)
                begin
                    good = held_valid && (running_chk == held_byte);
                    has = 1'b1;
                    r = mk_result(good ? KIND_GOOD : KIND_CHKERR, '0, byte_cnt, exp_seq, 1'b1);
                    pstate = PS_HUNT;
                    if (good) exp_seq = ~exp_seq;
                end
                else if (b == esc) pstate = PS_ESC;
                else shift_in_data(b, has, r);
            end
            PS_ESC:
            begin
                if (b == flag)
                begin
                    pstate = PS_HUNT;
                    has = 1'b1;
                    r = mk_result(KIND_ABORT, '0, byte_cnt, exp_seq, 1'b1);
                end
                else
                begin
                    pstate = PS_DATA;
                    if (b == reg_val[CFG_FLAG_ESC]) shift_in_data(flag, has, r);
                    else if (b == reg_val[CFG_ESCAPE_ESC]) shift_in_data(esc, has, r);
                end
            end
            default:
            begin
                pstate = (b == flag) ? PS_FLAG : PS_HUNT;
            end
        endcase
    endfunction

    // Stuffed line bytes for one payload byte
    function automatic void stuff_byte(input logic [ByteW-1:0] d);
        if (d == reg_val[CFG_FLAG])
        begin
            line_q.push_back(reg_val[CFG_ESCAPE]);
            line_q.push_back(reg_val[CFG_FLAG_ESC]);
        end
        else if (d == reg_val[CFG_ESCAPE])
        begin
            line_q.push_back(reg_val[CFG_ESCAPE]);
            line_q.push_back(reg_val[CFG_ESCAPE_ESC]);
        end
        else line_q.push_back(d);
    endfunction

    // Build one frame (mostly well formed) into line_q
    function automatic void build_frame(input bit long_frame);
        int unsigned sel;
        int unsigned len;
        logic [ByteW-1:0] ctrl;
        logic [ByteW-1:0] hdr;
        logic [ByteW-1:0] chk;
        logic [ByteW-1:0] d;
        logic [ByteW-1:0] junk;
        logic s;
        sel = long_frame ? 99 : $urandom_range(0, 99);
        // line noise
        if (sel < 8)
        begin
            repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
            line_q.push_back(reg_val[CFG_FLAG]);
        s = (sel < 16) ? ~gen_seq : gen_seq;
        ctrl = s ? reg_val[CFG_CTRL_SEQ1] : reg_val[CFG_CTRL_SEQ0];
        hdr = reg_val[CFG_ADDRESS] ^ ctrl;
        // duplicate, or a resync if the guessed bit was stale
        if (sel < 16)
        begin
            line_q.push_back(reg_val[CFG_ADDRESS]);
            line_q.push_back(ctrl);
            return;
        end
        // broken header
        if (sel < 22)
        begin
            case ($urandom_range(0, 2))
                0: line_q.push_back(reg_val[CFG_ADDRESS] ^ 8'($urandom_range(1, 255)));
                1:
                begin
                    line_q.push_back(reg_val[CFG_ADDRESS]);
                    line_q.push_back(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    line_q.push_back(reg_val[CFG_ADDRESS]);
                    line_q.push_back(ctrl);
                    line_q.push_back(hdr ^ 8'($urandom_range(1, 255)));
                end
            endcase
            return;
        end
        line_q.push_back(reg_val[CFG_ADDRESS]);
        line_q.push_back(ctrl);
        line_q.push_back(hdr);
        if (long_frame) len = MAX_PAYLOAD + 80;
        else if ($urandom_range(0, 29) == 0) len = $urandom_range(30, 150);
        else len = $urandom_range(0, 16);
        chk = hdr;
        for (int unsigned i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 11))
                0: d = reg_val[CFG_FLAG];
                1: d = reg_val[CFG_ESCAPE];
                default: d = 8'($urandom_range(0, 255));
            endcase
            chk = chk ^ d;
            stuff_byte(d);
            if ($urandom_range(0, 24) == 0)
            begin
                junk = 8'($urandom_range(0, 255));
                if (junk != reg_val[CFG_FLAG] && junk != reg_val[CFG_FLAG_ESC] &&
                    junk != reg_val[CFG_ESCAPE_ESC])
                begin
                    line_q.push_back(reg_val[CFG_ESCAPE]);
                    line_q.push_back(junk);
                end
            end
        end
        // escape abort
        if (sel < 30)
        begin
            line_q.push_back(reg_val[CFG_ESCAPE]);
            line_q.push_back(reg_val[CFG_FLAG]);
            return;
        end
        if (sel < 40) chk = chk ^ 8'($urandom_range(1, 255));
        else gen_seq = ~gen_seq;
        stuff_byte(chk);
        line_q.push_back(reg_val[CFG_FLAG]);
    endfunction

    // Offer one line byte and hold it until taken
    task automatic send_line_byte(input line_item_t it);
        int unsigned gap;
        gap = source_gaps_on ? pick_gap() : 0;
        sent_q.push_back(it);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= it.rx;
        do @(posedge clk); while (!rx_ch.ready);
    endtask

    task automatic run_random(input int unsigned n_bytes, input bit with_long);
        line_item_t it;
        int unsigned sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            line_q.delete();
            build_frame(with_long && sent == 0);
            foreach (line_q[i])
            begin
                it = '0;
                it.rx = line_q[i];
                send_line_byte(it);
            end
            sent += line_q.size();
        end
        rx_ch.valid <= 1'b0;
    endtask

    // Wait until every expected item is out and the pipeline is empty
    task automatic drain_pipeline();
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        reg_val[idx] = val;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [ByteW-1:0] flag, esc, fesc, eesc, addr, c0, c1);
        drain_pipeline();
        write_reg(CFG_FLAG, flag);
        write_reg(CFG_ESCAPE, esc);
        write_reg(CFG_FLAG_ESC, fesc);
        write_reg(CFG_ESCAPE_ESC, eesc);
        write_reg(CFG_ADDRESS, addr);
        write_reg(CFG_CTRL_SEQ0, c0);
        write_reg(CFG_CTRL_SEQ1, c1);
        cfg_we <= 1'b0;
    endtask

    // Random registers; delimiter, escape pair and address kept apart
    task automatic random_config();
        logic [ByteW-1:0] v [5];
        logic [ByteW-1:0] c0;
        logic [ByteW-1:0] c1;
        bit clash;
        do
        begin
            foreach (v[i]) v[i] = 8'($urandom_range(0, 255));
            clash = 1'b0;
            for (int i = 0; i < 5; i++)
                for (int j = i + 1; j < 5; j++)
                    if (v[i] == v[j]) clash = 1'b1;
        end
        while (clash);
        do c0 = 8'($urandom_range(0, 255)); while (c0 == v[0]);
        do c1 = 8'($urandom_range(0, 255)); while (c1 == v[0] || c1 == c0);
        apply_config(v[0], v[1], v[2], v[3], v[4], c0, c1);
    endtask

    // Input and result monitor
    always @(posedge clk)
    begin
        line_item_t it;
        frame_res_t r;
        frame_res_t want;
        bit has;
        if (rst_n)
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                it = sent_q.pop_front();
                deframe_step(rx_ch.rx_byte, has, r);
                if (it.typed)
                begin
                    has = 1'b1;
                    r = mk_result(it.kind, '0, it.len, it.seq, 1'b1);
                end
                if (has) expected_q.push_back(r);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result kind %0d with nothing expected",
                                              res_ch.kind));
                else
                begin
                    want = expected_q.pop_front();
                    if (res_ch.kind !== want.kind)
                        report_mismatch($sformatf("kind got %0d want %0d",
                                                  res_ch.kind, want.kind));
                    if (res_ch.payload_byte !== want.payload_byte)
                        report_mismatch($sformatf("payload_byte got %0h want %0h",
                                                  res_ch.payload_byte, want.payload_byte));
                    if (res_ch.frame_length !== want.frame_length)
                        report_mismatch($sformatf("frame_length got %0d want %0d",
                                                  res_ch.frame_length, want.frame_length));
                    if (res_ch.seq_bit !== want.seq_bit)
                        report_mismatch($sformatf("seq_bit got %0b want %0b",
                                                  res_ch.seq_bit, want.seq_bit));
                    if (res_ch.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end got %0b want %0b",
                                                  res_ch.frame_end, want.frame_end));
                end
            end
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_info_frame_deframer: done, errors");
            $finish;
        end
        else idle_cycles <= idle_cycles + 1;
    end

    // Result side back-pressure
    initial
    begin
        int unsigned stall;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            stall = sink_stalls_on ? pick_gap() : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Reset, phases and end of run
    initial
    begin
        reg_val[CFG_FLAG] = FLAG_RST;
        reg_val[CFG_ESCAPE] = ESCAPE_RST;
        reg_val[CFG_FLAG_ESC] = FLAG_ESC_RST;
        reg_val[CFG_ESCAPE_ESC] = ESCAPE_ESC_RST;
        reg_val[CFG_ADDRESS] = ADDRESS_RST;
        reg_val[CFG_CTRL_SEQ0] = CTRL_SEQ0_RST;
        reg_val[CFG_CTRL_SEQ1] = CTRL_SEQ1_RST;
        reg_val[7] = '0;
        rst_n <= 1'b0;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed bytes under the reset registers
        for (int unsigned i = 0; i < DIR_ROWS; i++) send_line_byte(DIR_TABLE[i]);
        rx_ch.valid <= 1'b0;
        run_random(150, 1'b0);

        // escaped flag code equal to the flag itself
        apply_config(8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h00, 8'h80);
        run_random(100, 1'b0);

        // both control codes equal; escaped escape code equal to the flag
        apply_config(8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h7F, 8'h7F);
        run_random(100, 1'b0);

        // random registers, first stretch with no idling on either side
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        random_config();
        run_random(100, 1'b0);
        repeat (2)
        begin
            source_gaps_on = $urandom_range(0, 3) != 0;
            sink_stalls_on = $urandom_range(0, 3) != 0;
            random_config();
            run_random(100, 1'b0);
        end

        // back to reset values, with one frame past the length cap
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        apply_config(FLAG_RST, ESCAPE_RST, FLAG_ESC_RST, ESCAPE_ESC_RST, ADDRESS_RST,
                     CTRL_SEQ0_RST, CTRL_SEQ1_RST);
        run_random(100, 1'b1);

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_info_frame_deframer: done, clean");
        else
            $display("tb_info_frame_deframer: done, errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/ifd_pkg.sv
src/ifd_ifs.sv
src/info_frame_deframer.sv
test/tb_info_frame_deframer.sv
